/* src/spwm_pkg.sv */
// Package for the shared-period multichannel PWM unit.
// Holds widths, request codes and the command struct passed to the channel bank.
// Depends on nothing.
package spwm_pkg;

  localparam int CHANNELS    = 15;
  localparam int COUNT_WIDTH = 32;

  localparam int REQ_W   = 3;
  localparam int CHAN_W  = 4;
  localparam int VALUE_W = 32;
  localparam int PWM_W   = 15;
  localparam int NOW_W   = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_PERIOD = 3'd1,
    REQ_DUTY   = 3'd2,
    REQ_CTRL   = 3'd3,
    REQ_RUN    = 3'd4
  } req_t;

  typedef struct packed {
    logic              tick;
    logic              per_hit;
    logic              duty_we;
    logic              ctrl_we;
    logic [CHAN_W-1:0] chan;
    logic              enable;
    logic              polarity;
    count_t            count;
    count_t            value;
  } chan_cmd_t;

endpackage

/* src/spwm_chan_bank.sv */
// Channel bank of the shared-period PWM unit: duty compares, enable and polarity bits
// and output levels, one set per channel. Depends on spwm_pkg.
module spwm_chan_bank (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spwm_pkg::chan_cmd_t                   cmd,
  output logic [spwm_pkg::CHANNELS-1:0]         level_nxt
);
  import spwm_pkg::*;

  count_t              duty_r   [CHANNELS];
  logic [CHANNELS-1:0] enable_r;
  logic [CHANNELS-1:0] invert_r;
  logic [CHANNELS-1:0] level_r;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    logic sel;

    assign sel = (cmd.chan == CHAN_W'(g));

    always_comb begin
      level_nxt[g] = level_r[g];
      if (cmd.tick && enable_r[g]) begin
        if (cmd.per_hit) begin
          level_nxt[g] = ~invert_r[g];
        end else if (cmd.count == duty_r[g]) begin
          level_nxt[g] = invert_r[g];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        duty_r[g]   <= '0;
        enable_r[g] <= 1'b0;
        invert_r[g] <= 1'b0;
        level_r[g]  <= 1'b0;
      end else begin
        level_r[g] <= level_nxt[g];
        if (cmd.duty_we && sel) begin
          duty_r[g] <= cmd.value;
        end
        if (cmd.ctrl_we && sel) begin
          enable_r[g] <= cmd.enable;
          invert_r[g] <= cmd.polarity;
        end
      end
    end
  end

endmodule

/* src/shared_period_multichannel_pwm_unit.sv */
// Top level of the shared-period multichannel PWM unit: input register, counter,
// period compare and result register. Depends on spwm_pkg and spwm_chan_bank.
//
//   channel | direction | handshake         | word
//   in_     | input     | in_valid/in_stall | request: type, channel, value, enable, polarity
//   out_    | output    | out_valid/out_stall | levels, counter value, period hit
//
// Every word is held in the input register, while the counter, period compare
// and all channel compares settle together in front of the result register.
// One word is accepted per cycle while no stalled result blocks the input register.
// Synchronous reset clears the counter, channels and run flag and sets the period to maximum.
// The input register keeps accepting while a result waits, until both stages are full.
module shared_period_multichannel_pwm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spwm_pkg::REQ_W-1:0]     in_req_type,
  input  logic [spwm_pkg::CHAN_W-1:0]    in_channel,
  input  logic [spwm_pkg::VALUE_W-1:0]   in_value,
  input  logic                           in_enable,
  input  logic                           in_polarity,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spwm_pkg::PWM_W-1:0]     out_pwm_out,
  output logic [spwm_pkg::NOW_W-1:0]     out_count_now,
  output logic                           out_period_hit
);
  import spwm_pkg::*;

  logic              in_v_r;
  logic [REQ_W-1:0]  req_r;
  logic [CHAN_W-1:0] chan_r;
  count_t            value_r;
  logic              en_r;
  logic              pol_r;

  count_t count_r;
  count_t count_nxt;
  count_t limit_r;
  logic   running_r;

  logic                out_v_r;
  logic [PWM_W-1:0]    pwm_r;
  logic [NOW_W-1:0]    now_r;
  logic                hit_r;

  logic                proc;
  logic                is_tick;
  logic                per;
  chan_cmd_t           cmd;
  logic [CHANNELS-1:0] level_nxt;

  assign proc     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !proc;

  assign per     = (count_r == limit_r);
  assign is_tick = proc && (req_r == REQ_TICK) && running_r;

  always_comb begin
    count_nxt = count_r;
    if (is_tick) begin
      count_nxt = per ? '0 : count_r + 1'b1;
    end
  end

  always_comb begin
    cmd.tick     = is_tick;
    cmd.per_hit  = per;
    cmd.duty_we  = proc && (req_r == REQ_DUTY);
    cmd.ctrl_we  = proc && (req_r == REQ_CTRL);
    cmd.chan     = chan_r;
    cmd.enable   = en_r;
    cmd.polarity = pol_r;
    cmd.count    = count_r;
    cmd.value    = value_r;
  end

  spwm_chan_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .level_nxt (level_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r   <= in_req_type;
      chan_r  <= in_channel;
      value_r <= in_value[COUNT_WIDTH-1:0];
      en_r    <= in_enable;
      pol_r   <= in_polarity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      limit_r   <= '1;
      running_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (proc) begin
        case (req_r)
          REQ_PERIOD: limit_r   <= (value_r == '0) ? '0 : value_r - 1'b1;
          REQ_RUN:    running_r <= en_r;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      pwm_r <= PWM_W'(level_nxt);
      now_r <= NOW_W'(count_nxt);
      hit_r <= is_tick && per;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pwm_out    = pwm_r;
  assign out_count_now  = now_r;
  assign out_period_hit = hit_r;

endmodule

/* src/spwm_checker.sv */
// Port-level checker for the shared-period multichannel PWM unit, with its bind.
// Depends on spwm_pkg and on the top level's port names.
module spwm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [spwm_pkg::PWM_W-1:0]   out_pwm_out,
  input logic [spwm_pkg::NOW_W-1:0]   out_count_now,
  input logic                         out_period_hit
);
  import spwm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pwm_out) && $stable(out_count_now)
                               && $stable(out_period_hit))
    else $error("stalled result word changed");

  a_hit_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_hit |-> out_count_now == '0)
    else $error("period hit without counter wrap");

  a_reset_idle: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind shared_period_multichannel_pwm_unit spwm_checker u_spwm_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the shared-period multichannel PWM unit.
// Drives request words with random gaps and stalls and checks every result word against
// an internal predictor; depends on spwm_pkg and shared_period_multichannel_pwm_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import spwm_pkg::*;

  typedef struct packed {
    logic [REQ_W-1:0]   req;
    logic [CHAN_W-1:0]  chan;
    logic [VALUE_W-1:0] value;
    logic               enable;
    logic               polarity;
  } req_word_t;

  typedef struct packed {
    logic [PWM_W-1:0] pwm;
    logic [NOW_W-1:0] count;
    logic             hit;
  } level_word_t;

  typedef struct packed {
    count_t                  count;
    count_t                  limit;
    count_t [CHANNELS-1:0]   duty;
    logic [CHANNELS-1:0]     en;
    logic [CHANNELS-1:0]     inv;
    logic [CHANNELS-1:0]     level;
    logic                    run;
  } pwm_state_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [CHAN_W-1:0] in_channel = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic in_enable = 1'b0;
  logic in_polarity = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PWM_W-1:0] out_pwm_out;
  logic [NOW_W-1:0] out_count_now;
  logic out_period_hit;

  logic hold_off = 1'b0;

  req_word_t   pending_q[$];
  level_word_t level_q[$];
  req_word_t   cur;
  pwm_state_t  timer_now;
  pwm_state_t  timer_plan;
  int n_total = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_wraps = 0;
  int n_errors = 0;
  int gap_left = 0;
  int stall_left = 0;

  shared_period_multichannel_pwm_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_channel     (in_channel),
    .in_value       (in_value),
    .in_enable      (in_enable),
    .in_polarity    (in_polarity),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pwm_out    (out_pwm_out),
    .out_count_now  (out_count_now),
    .out_period_hit (out_period_hit)
  );

  function automatic pwm_state_t timer_reset_state();
    pwm_state_t s;
    s = '0;
    s.limit = '1;
    return s;
  endfunction

  function automatic void timer_step(inout pwm_state_t s, input req_word_t w,
                                     output level_word_t r);
    logic per;
    count_t v;
    r = '0;
    case (w.req)
      REQ_TICK: begin
        if (s.run) begin
          per = (s.count == s.limit);
          for (int ch = 0; ch < CHANNELS; ch++) begin
            if (s.en[ch]) begin
              if (per) s.level[ch] = !s.inv[ch];
              else if (s.count == s.duty[ch]) s.level[ch] = s.inv[ch];
            end
          end
          if (per) begin
            s.count = '0;
            r.hit = 1'b1;
          end else begin
            s.count = s.count + 1'b1;
          end
        end
      end
      REQ_PERIOD: begin
        v = (w.value == '0) ? count_t'(1) : count_t'(w.value);
        s.limit = v - 1'b1;
      end
      REQ_DUTY: begin
        if (w.chan < CHANNELS) s.duty[w.chan] = w.value;
      end
      REQ_CTRL: begin
        if (w.chan < CHANNELS) begin
          s.en[w.chan] = w.enable;
          s.inv[w.chan] = w.polarity;
        end
      end
      REQ_RUN: begin
        s.run = w.enable;
      end
      default: begin
      end
    endcase
    r.pwm = s.level;
    r.count = s.count;
  endfunction

  function automatic req_word_t make_word(logic [REQ_W-1:0] req, int chan, count_t value,
                                          logic en, logic pol);
    req_word_t w;
    w.req = req;
    w.chan = chan[CHAN_W-1:0];
    w.value = value;
    w.enable = en;
    w.polarity = pol;
    return w;
  endfunction

  function automatic void queue_word(req_word_t w);
    level_word_t dummy;
    timer_step(timer_plan, w, dummy);
    pending_q.push_back(w);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Long receiver hold-off once the run is well under way.
  initial begin
    wait (n_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    level_word_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        timer_step(timer_now, cur, r);
        level_q.push_back(r);
        n_sent++;
        gap_left = (hold_off || (n_sent / 60) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          in_req_type <= cur.req;
          in_channel <= cur.chan;
          in_value <= cur.value;
          in_enable <= cur.enable;
          in_polarity <= cur.polarity;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    level_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_period_hit) n_wraps++;
        if (level_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual pwm=%h count=%h hit=%b",
                   $time, out_pwm_out, out_count_now, out_period_hit);
          n_errors++;
        end else begin
          exp_w = level_q.pop_front();
          if (out_pwm_out !== exp_w.pwm) begin
            $display("%0t: pwm_out mismatch: expected %h, actual %h",
                     $time, exp_w.pwm, out_pwm_out);
            n_errors++;
          end
          if (out_count_now !== exp_w.count) begin
            $display("%0t: count_now mismatch: expected %h, actual %h",
                     $time, exp_w.count, out_count_now);
            n_errors++;
          end
          if (out_period_hit !== exp_w.hit) begin
            $display("%0t: period_hit mismatch: expected %b, actual %b",
                     $time, exp_w.hit, out_period_hit);
            n_errors++;
          end
        end
        stall_left = ((n_results / 50) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  initial begin
    req_word_t w;
    int sel;
    int hi;
    timer_now = timer_reset_state();
    timer_plan = timer_reset_state();

    queue_word(make_word(REQ_TICK, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_RUN, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(3'd5, 3, 32'h1234_5678, 1'b1, 1'b1));
    queue_word(make_word(3'd6, 15, '1, 1'b1, 1'b0));
    queue_word(make_word(3'd7, 7, '0, 1'b0, 1'b1));
    queue_word(make_word(REQ_PERIOD, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_DUTY, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_DUTY, 14, '1, 1'b0, 1'b0));
    queue_word(make_word(REQ_DUTY, 15, 32'd5, 1'b0, 1'b0));
    queue_word(make_word(REQ_CTRL, 0, '0, 1'b1, 1'b0));
    queue_word(make_word(REQ_CTRL, 14, '0, 1'b1, 1'b1));
    queue_word(make_word(REQ_CTRL, 15, '0, 1'b1, 1'b1));
    queue_word(make_word(REQ_RUN, 0, '0, 1'b1, 1'b0));
    queue_word(make_word(REQ_TICK, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_TICK, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_PERIOD, 0, 32'd4, 1'b0, 1'b0));
    queue_word(make_word(REQ_DUTY, 1, 32'd2, 1'b0, 1'b0));
    queue_word(make_word(REQ_CTRL, 1, '0, 1'b1, 1'b0));
    repeat (6) queue_word(make_word(REQ_TICK, 0, '0, 1'b0, 1'b0));
    queue_word(make_word(REQ_PERIOD, 0, '1, 1'b0, 1'b0));

    while (pending_q.size() < 850) begin
      w.req = REQ_TICK;
      w.chan = CHAN_W'($urandom_range(0, 15));
      w.value = $urandom;
      w.enable = 1'($urandom_range(0, 1));
      w.polarity = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (timer_plan.count > timer_plan.limit && sel < 15) begin
        w.req = REQ_PERIOD;
        w.value = timer_plan.count + 1 + $urandom_range(0, 15);
      end else if (sel < 55) begin
        w.req = REQ_TICK;
      end else if (sel < 62) begin
        w.req = REQ_PERIOD;
        sel = $urandom_range(0, 19);
        if (sel == 0) w.value = '0;
        else if (sel < 17) w.value = $urandom_range(1, 12);
      end else if (sel < 74) begin
        w.req = REQ_DUTY;
        hi = (timer_plan.limit < 30) ? int'(timer_plan.limit) + 2 : 30;
        if ($urandom_range(0, 99) < 85) w.value = $urandom_range(0, hi);
      end else if (sel < 86) begin
        w.req = REQ_CTRL;
        w.enable = ($urandom_range(0, 3) != 0);
      end else if (sel < 92) begin
        w.req = REQ_RUN;
        w.enable = ($urandom_range(0, 99) < 85);
      end else if (sel < 95) begin
        w.req = REQ_W'($urandom_range(5, 7));
      end
      queue_word(w);
    end
    n_total = pending_q.size();

    wait (n_sent == n_total);
    wait (level_q.size() == 0);
    repeat (10) @(posedge clk);
    $display("Checked %0d result words from %0d request words, %0d of them period wraps.",
             n_results, n_total, n_wraps);
    if (n_errors == 0 && level_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
src/spwm_pkg.sv
src/spwm_chan_bank.sv
src/shared_period_multichannel_pwm_unit.sv
src/spwm_checker.sv
sim/tb_top.sv
